[design/slsr_pkg.sv]
package slsr_pkg;

   // Row records per sample before the rest are skipped
   localparam int MAX_ROWS = 64;
   localparam int CNT_W    = $clog2(MAX_ROWS + 1);

   localparam int ROW_W    = 16;
   localparam int POS_W    = 24;
   localparam int PIX_W    = 12;
   localparam int RATE_W   = 24;
   localparam int HALF_W   = 10;
   localparam int FRAC_W   = 8;
   localparam int PROD_W   = RATE_W + ROW_W;
   localparam int LIM_W    = PROD_W - FRAC_W;
   localparam int EXT_W    = LIM_W + 2;
   localparam int EDGE_W   = POS_W + 2;
   localparam int PIXQ_W   = EDGE_W - 1 - FRAC_W;

   // Job queue between front and back; depth is a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_SLEW_RATE       = 2'd0;
   localparam csr_index_type CSR_BAND_HALF_WIDTH = 2'd1;
   localparam csr_index_type CSR_IMAGE_WIDTH     = 2'd2;

   localparam logic [RATE_W-1:0] RST_SLEW_RATE       = 24'd13107;
   localparam logic [HALF_W-1:0] RST_BAND_HALF_WIDTH = 10'd20;
   localparam logic [PIX_W-1:0]  RST_IMAGE_WIDTH     = 12'd400;

   typedef struct packed {
      logic        [ROW_W-1:0] target_row;
      logic signed [POS_W-1:0] center_pos;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] row_index;
      logic [PIX_W-1:0] left_start;
      logic [PIX_W-1:0] left_end;
      logic [PIX_W-1:0] right_start;
      logic [PIX_W-1:0] right_end;
      logic             last_row;
      logic             rows_clipped;
   } rsp_type;

   typedef struct packed {
      logic [RATE_W-1:0] slew_rate;
      logic [HALF_W-1:0] band_half_width;
      logic [PIX_W-1:0]  image_width;
   } cfg_type;

   typedef struct packed {
      logic [ROW_W-1:0] first_row;
      logic [CNT_W-1:0] row_count;
      logic [PIX_W-1:0] left_start;
      logic [PIX_W-1:0] left_end;
      logic [PIX_W-1:0] right_start;
      logic [PIX_W-1:0] right_end;
      logic             rows_clipped;
   } job_type;

endpackage

[design/slsr_front.sv]
module slsr_front import slsr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    push_valid,
   output job_type push_job,
   input  logic    push_full
);

   typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_CLAMP, ST_EDGE, ST_PUSH} state_type;

   state_type               state_ff;
   logic signed [POS_W-1:0] prev_center_ff;
   logic [ROW_W-1:0]        prev_time_ff;
   logic [ROW_W-1:0]        row_counter_ff;
   logic                    seen_first_ff;
   logic signed [POS_W-1:0] center_ff;
   logic [ROW_W-1:0]        elapsed_ff;
   logic [PROD_W-1:0]       product_ff;
   logic [ROW_W-1:0]        first_row_ff;
   logic [CNT_W-1:0]        count_ff;
   logic                    has_rows_ff;
   logic                    clipped_ff;
   logic [PIX_W-1:0]        ls_ff;
   logic [PIX_W-1:0]        le_ff;

   logic [ROW_W-1:0]        elapsed_in;
   logic [ROW_W-1:0]        row_span;
   logic                    has_rows_in;
   logic                    clipped_in;
   logic [CNT_W-1:0]        count_in;
   logic [LIM_W-1:0]        limit;
   logic signed [EXT_W-1:0] pc_ext, lim_ext, lo_ext, hi_ext, c_ext, clamp_ext;
   logic signed [POS_W-1:0] center_in;
   logic signed [EDGE_W-1:0] hw_ext, q_lo, q_hi;
   logic [PIX_W-1:0]        ls_raw, le_raw;

   // Q16.8 to pixel, truncating toward zero, clamped to 0..w
   function automatic logic [PIX_W-1:0] to_pixel(input logic signed [EDGE_W-1:0] q,
                                                 input logic [PIX_W-1:0] w);
      logic [PIXQ_W-1:0] p;
      logic [PIX_W-1:0]  r;
      p = q[EDGE_W-2:FRAC_W];
      if (q <= 0) begin
         r = '0;
      end else if (p > PIXQ_W'(w)) begin
         r = w;
      end else begin
         r = p[PIX_W-1:0];
      end
      return r;
   endfunction

   // Classify the incoming sample against the running state
   assign elapsed_in  = (req_data.target_row > prev_time_ff) ?
                        (req_data.target_row - prev_time_ff) : '0;
   assign has_rows_in = req_data.target_row > row_counter_ff;
   assign row_span    = req_data.target_row - row_counter_ff;
   assign clipped_in  = row_span > ROW_W'(MAX_ROWS);
   assign count_in    = clipped_in ? CNT_W'(MAX_ROWS) : row_span[CNT_W-1:0];

   // Slew window around the previous center
   assign limit     = product_ff[PROD_W-1:FRAC_W];
   assign pc_ext    = EXT_W'(prev_center_ff);
   assign lim_ext   = $signed({2'b00, limit});
   assign lo_ext    = pc_ext - lim_ext;
   assign hi_ext    = pc_ext + lim_ext;
   assign c_ext     = EXT_W'(center_ff);

   always_comb begin
      priority if (c_ext < lo_ext) begin
         clamp_ext = lo_ext;
      end else if (c_ext > hi_ext) begin
         clamp_ext = hi_ext;
      end else begin
         clamp_ext = c_ext;
      end
   end

   assign center_in = seen_first_ff ? clamp_ext[POS_W-1:0] : center_ff;

   // Band edges in Q16.8
   assign hw_ext = $signed(EDGE_W'({cfg.band_half_width, 8'h00}));
   assign q_lo   = EDGE_W'(center_ff) - hw_ext;
   assign q_hi   = EDGE_W'(center_ff) + hw_ext;
   assign ls_raw = to_pixel(q_lo, cfg.image_width);
   assign le_raw = to_pixel(q_hi, cfg.image_width);

   assign req_stall  = (state_ff != ST_IDLE);
   assign push_valid = (state_ff == ST_PUSH) && has_rows_ff;

   always_comb begin
      push_job.first_row    = first_row_ff;
      push_job.row_count    = count_ff;
      push_job.left_start   = ls_ff;
      push_job.left_end     = le_ff;
      push_job.right_start  = cfg.image_width - le_ff;
      push_job.right_end    = cfg.image_width - ls_ff;
      push_job.rows_clipped = clipped_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         prev_center_ff <= '0;
         prev_time_ff   <= '0;
         row_counter_ff <= '0;
         seen_first_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  center_ff    <= req_data.center_pos;
                  elapsed_ff   <= elapsed_in;
                  prev_time_ff <= req_data.target_row;
                  has_rows_ff  <= has_rows_in;
                  clipped_ff   <= clipped_in;
                  count_ff     <= count_in;
                  first_row_ff <= row_counter_ff;
                  if (has_rows_in) begin
                     row_counter_ff <= req_data.target_row;
                  end
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               product_ff <= PROD_W'(cfg.slew_rate) * PROD_W'(elapsed_ff);
               state_ff   <= ST_CLAMP;
            end
            ST_CLAMP: begin
               center_ff      <= center_in;
               prev_center_ff <= center_in;
               seen_first_ff  <= 1'b1;
               state_ff       <= ST_EDGE;
            end
            ST_EDGE: begin
               ls_ff    <= (ls_raw > le_raw) ? le_raw : ls_raw;
               le_ff    <= le_raw;
               state_ff <= ST_PUSH;
            end
            ST_PUSH: begin
               // drop samples that owe no rows; otherwise hold until the queue has room
               if (!has_rows_ff || !push_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[design/slsr_queue.sv]
module slsr_queue import slsr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    push_full,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     fill_ff;
   logic                do_push;
   logic                do_pop;

   assign push_full = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            entry_ff[wr_ptr_ff] <= push_job;
            wr_ptr_ff           <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({do_push, do_pop})
            2'b10:   fill_ff <= fill_ff + 1'b1;
            2'b01:   fill_ff <= fill_ff - 1'b1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

[design/slsr_emit.sv]
module slsr_emit import slsr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    pop_valid,
   output logic    pop_ready,
   input  job_type pop_job,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic             active_ff;
   job_type          job_ff;
   logic [ROW_W-1:0] row_ff;
   logic [CNT_W-1:0] left_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pop_ready = !active_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // advance one row whenever the output register is free
         if (slot_free) begin
            rsp_valid_ff <= active_ff;
            if (active_ff) begin
               rsp_ff.row_index    <= row_ff;
               rsp_ff.left_start   <= job_ff.left_start;
               rsp_ff.left_end     <= job_ff.left_end;
               rsp_ff.right_start  <= job_ff.right_start;
               rsp_ff.right_end    <= job_ff.right_end;
               rsp_ff.last_row     <= (left_ff == CNT_W'(1));
               rsp_ff.rows_clipped <= job_ff.rows_clipped;
               row_ff              <= row_ff + 1'b1;
               left_ff             <= left_ff - 1'b1;
               if (left_ff == CNT_W'(1)) begin
                  active_ff <= 1'b0;
               end
            end
         end
         if (!active_ff && pop_valid) begin
            active_ff <= 1'b1;
            job_ff    <= pop_job;
            row_ff    <= pop_job.first_row;
            left_ff   <= pop_job.row_count;
         end
      end
   end

endmodule

[design/slew_limited_span_rasterizer.sv]
// The first row record of a sample follows the front's multiply, clamp, edge and push
// states, the job queue and the emitter's registers; then one row record per cycle
// while rsp_stall is low (at most MAX_ROWS per sample). The front takes no new sample
// until its push step ends; a two-entry job queue lets it run ahead of the row emitter.
// Reset: synchronous, active high; clears the center, time and row state and
// restores the default slew rate, band half width and image width.
module slew_limited_span_rasterizer import slsr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_data
);

   cfg_type cfg_ff;
   logic    push_valid;
   job_type push_job;
   logic    push_full;
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_job;

   // Configuration writes are always accepted and registered; unknown indexes are ignored
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slew_rate       <= RST_SLEW_RATE;
         cfg_ff.band_half_width <= RST_BAND_HALF_WIDTH;
         cfg_ff.image_width     <= RST_IMAGE_WIDTH;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SLEW_RATE:       cfg_ff.slew_rate       <= csr_data[RATE_W-1:0];
            CSR_BAND_HALF_WIDTH: cfg_ff.band_half_width <= csr_data[HALF_W-1:0];
            CSR_IMAGE_WIDTH:     cfg_ff.image_width     <= csr_data[PIX_W-1:0];
            default:             cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   // Front: slew-limit the center, build the band, and classify the rows owed
   slsr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_full  (push_full)
   );

   // Short job queue so the front and the row emitter stall independently
   slsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_full  (push_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // Back: walk the rows of each job, one transfer per cycle while rsp_stall is low
   slsr_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A band never runs backwards
   a_band_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.left_start <= rsp_data.left_end)
      else $error("left band start past its end");

   // The mirrored band starts where the left band ends, reflected about the width
   a_mirror: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.right_start} + {1'b0, rsp_data.left_end})
                    == {1'b0, cfg_ff.image_width})
      else $error("mirrored band does not match left band");

   // Rows of one sample follow back to back
   a_row_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_row |=>
         rsp_valid && (rsp_data.row_index == $past(rsp_data.row_index) + 16'd1))
      else $error("row run broken before last row");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import slsr_pkg::*;

   localparam int ITEMS_PER_PHASE = 43;
   localparam int NUM_PHASES      = 8;
   // Cycles to let the front finish a sample that makes no row records
   localparam int SETTLE_CYCLES   = 16;
   localparam int CYCLE_LIMIT     = 1_500_000;
   localparam int MAX_REPORTS     = 50;

   // Span predictor and store of expected row records
   class span_scoreboard;
      logic [RATE_W-1:0] slew_rate;
      logic [HALF_W-1:0] half_width;
      logic [PIX_W-1:0]  image_width;
      longint center;
      longint last_time;
      longint next_row;
      bit     seeded;
      rsp_type span_q[$];
      int errors;

      function new();
         slew_rate   = RST_SLEW_RATE;
         half_width  = RST_BAND_HALF_WIDTH;
         image_width = RST_IMAGE_WIDTH;
         center      = 0;
         last_time   = 0;
         next_row    = 0;
         seeded      = 1'b0;
         errors      = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_SLEW_RATE:       slew_rate   = value[RATE_W-1:0];
            CSR_BAND_HALF_WIDTH: half_width  = value[HALF_W-1:0];
            CSR_IMAGE_WIDTH:     image_width = value[PIX_W-1:0];
            default: ;
         endcase
      endfunction

      // Q16.8 edge to a pixel, truncated, then clamped to the image
      function longint to_pixel(longint q, longint w);
         longint p;
         if (q <= 0)
            return 0;
         p = q >> FRAC_W;
         return (p > w) ? w : p;
      endfunction

      function void note_sample(req_type s);
         longint c, elapsed, limit, w, hw, ls, le, rs, re, trow, count, emit;
         bit clipped;
         rsp_type r;
         c    = longint'($signed(s.center_pos));
         trow = longint'(s.target_row);
         if (!seeded) begin
            seeded = 1'b1;
         end else begin
            elapsed = (trow > last_time) ? trow - last_time : 0;
            limit   = (longint'(slew_rate) * elapsed) >> FRAC_W;
            if (c < center - limit) c = center - limit;
            if (c > center + limit) c = center + limit;
         end
         center    = c;
         last_time = trow;

         w  = longint'(image_width);
         hw = longint'(half_width) * 256;
         ls = to_pixel(c - hw, w);
         le = to_pixel(c + hw, w);
         if (ls > le)
            ls = le;
         rs = w - le;
         re = w - ls;

         if (trow <= next_row)
            return;
         count   = trow - next_row;
         clipped = (count > MAX_ROWS);
         emit    = clipped ? MAX_ROWS : count;
         for (longint k = 0; k < emit; k++) begin
            r.row_index    = ROW_W'(next_row + k);
            r.left_start   = ls[PIX_W-1:0];
            r.left_end     = le[PIX_W-1:0];
            r.right_start  = rs[PIX_W-1:0];
            r.right_end    = re[PIX_W-1:0];
            r.last_row     = (k == emit - 1);
            r.rows_clipped = clipped;
            span_q.push_back(r);
         end
         next_row = trow;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_record(rsp_type got);
         rsp_type want;
         if (span_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: row record with none expected, expected nothing, got row %0d",
                        $time, got.row_index);
            return;
         end
         want = span_q.pop_front();
         compare_field("row_index",    want.row_index,    got.row_index);
         compare_field("left_start",   want.left_start,   got.left_start);
         compare_field("left_end",     want.left_end,     got.left_end);
         compare_field("right_start",  want.right_start,  got.right_start);
         compare_field("right_end",    want.right_end,    got.right_end);
         compare_field("last_row",     want.last_row,     got.last_row);
         compare_field("rows_clipped", want.rows_clipped, got.rows_clipped);
      endfunction
   endclass

   // Every input of the block starts at a known value
   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_SLEW_RATE;
   logic [31:0]   csr_data  = '0;

   span_scoreboard sb = new();

   int unsigned req_idle_max = 6;
   int unsigned rsp_idle_max = 6;
   int unsigned rsp_hold;
   int unsigned hold_left   = 0;
   int unsigned cycle_count = 0;

   slew_limited_span_rasterizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Row record sink: check each transfer, then hold stall for a random
   // number of cycles before taking the next record
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         sb.check_record(rsp_data);
         rsp_hold = $urandom_range(0, rsp_idle_max);
         hold_left <= rsp_hold;
         rsp_stall <= (rsp_hold != 0);
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         if (hold_left == 1)
            rsp_stall <= 1'b0;
      end
   end

   // Present one sample and hold it until the transfer. Valid stays high
   // after the transfer; drop it only when a gap comes first, so valid is
   // never lowered and raised in the same step.
   task automatic send_sample(input logic [ROW_W-1:0] target, input logic [POS_W-1:0] pos);
      int unsigned gap;
      req_type s;
      gap = $urandom_range(0, req_idle_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      s.target_row = target;
      s.center_pos = pos;
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_sample(s);
   endtask

   // Stop sending, wait for every expected record, then let the front settle
   task automatic drain_records();
      req_valid <= 1'b0;
      while (sb.span_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register transfer; valid is left high for the next write
   task automatic put_reg(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic program_regs(input logic [RATE_W-1:0] slew, input logic [HALF_W-1:0] half,
                               input logic [PIX_W-1:0] width);
      put_reg(CSR_SLEW_RATE,       32'(slew));
      put_reg(CSR_BAND_HALF_WIDTH, 32'(half));
      put_reg(CSR_IMAGE_WIDTH,     32'(width));
      csr_valid <= 1'b0;
   endtask

   // Center mostly across the image and a margin past both sides;
   // sometimes anywhere in the 24-bit range
   function automatic logic [POS_W-1:0] pick_center();
      int span_px, margin_px;
      if ($urandom_range(0, 99) < 15)
         return POS_W'($urandom);
      margin_px = int'(sb.half_width) + 20;
      span_px   = int'(sb.image_width) + 2 * margin_px;
      return POS_W'(int'($urandom_range(0, span_px * 256)) - margin_px * 256);
   endfunction

   // Mostly a few rows past the running row counter, some long runs that
   // clip, some stale times that make no records
   function automatic logic [ROW_W-1:0] pick_target();
      int unsigned kind;
      longint t;
      kind = $urandom_range(0, 99);
      if (kind < 75)
         t = sb.next_row + $urandom_range(1, 8);
      else if (kind < 87)
         t = sb.next_row + $urandom_range(9, 140);
      else
         t = $urandom_range(0, int'(sb.next_row));
      // Keep headroom for the high-row samples at the end
      if (t > 60000)
         t = 60000;
      return ROW_W'(t);
   endfunction

   initial begin
      logic [RATE_W-1:0] slew;
      logic [HALF_W-1:0] half;
      logic [PIX_W-1:0]  width;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Default registers: seed at the top of the range, then slew hard
      // toward the bottom; rows not yet due; time going backwards; a run
      // longer than MAX_ROWS; a single row
      send_sample(16'd0,  24'h7FFFFF);
      send_sample(16'd3,  24'h800000);
      send_sample(16'd3,  POS_W'(100 * 256));
      send_sample(16'd1,  POS_W'(150 * 256));
      send_sample(16'd80, POS_W'(200 * 256));
      send_sample(16'd81, POS_W'(200 * 256));

      // Free slew, zero half width (empty band), widest image;
      // bands off the left and the right edge, and a fractional center
      drain_records();
      program_regs(24'hFFFFFF, 10'd0, 12'd4095);
      send_sample(16'd85, POS_W'(-5 * 256));
      send_sample(16'd90, POS_W'(5000 * 256));
      send_sample(16'd95, POS_W'(1000 * 256 + 128));

      // Zero image width: every span edge collapses to 0
      drain_records();
      program_regs(RST_SLEW_RATE, 10'd1023, 12'd0);
      send_sample(16'd97, POS_W'(300 * 256));
      send_sample(16'd99, POS_W'(-300 * 256));

      // No slew allowed: the center holds; one-pixel image
      drain_records();
      program_regs(24'd0, 10'd1023, 12'd1);
      send_sample(16'd100, 24'h7FFFFF);
      send_sample(16'd102, 24'h000000);

      // Random phases, each with its own register setting and idle mix
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_records();
         case (p)
            0: begin
               slew = 24'd0; half = 10'd0; width = 12'd1;
            end
            1: begin
               slew = 24'hFFFFFF; half = 10'd1023; width = 12'd4095;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: slew = RATE_W'($urandom_range(0, 4096));
                  1: slew = RATE_W'($urandom_range(0, 24'h0FFFFF));
                  2: slew = RATE_W'($urandom);
                  default: slew = RATE_W'($urandom_range(0, 1024));
               endcase
               half  = ($urandom_range(0, 1) != 0) ? HALF_W'($urandom_range(0, 64))
                                                   : HALF_W'($urandom);
               width = ($urandom_range(0, 1) != 0) ? PIX_W'($urandom_range(1, 800))
                                                   : PIX_W'($urandom_range(1, 4095));
            end
         endcase
         program_regs(slew, half, width);
         // Run some phases without idling on one side or the other
         req_idle_max = (p % 3 == 1) ? 0 : 6;
         rsp_idle_max = (p % 4 == 2) ? 0 : 6;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            send_sample(pick_target(), pick_center());
            // Hold off the sender once mid-phase until the sink catches up
            if (p == 3 && i == 20)
               drain_records();
         end
      end

      // High rows: drive the top bits of the time, clip at the top of the
      // row range, then go back to row 0
      drain_records();
      req_idle_max = 6;
      rsp_idle_max = 6;
      program_regs(RST_SLEW_RATE, 10'd7, 12'd4095);
      send_sample(ROW_W'(sb.next_row + 1), pick_center());
      send_sample(ROW_W'(16'h8000 + $urandom_range(0, 255)), pick_center());
      send_sample(16'hFFFF, pick_center());
      send_sample(16'hFFFF, pick_center());
      send_sample(16'h0000, pick_center());

      drain_records();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.span_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
